### rtl/core/accel_vector_magnitude_assert.svh
// Assertion macros for the accelerometer magnitude block.
// Included by the top level; no other dependencies.
`ifndef ACCEL_VECTOR_MAGNITUDE_ASSERT_SVH
`define ACCEL_VECTOR_MAGNITUDE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define AVM_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("avm: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define AVM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("avm: next-cycle check failed");

`endif

### rtl/core/avm_pkg.sv
// Shared constants and types for the accelerometer magnitude block.
// No dependencies; used by avm_lane and the top level under rtl/core.
`timescale 1ns / 1ps

package avm_pkg;

  // Sample and field widths
  localparam int SAMPLE_BITS_DEF = 14;
  localparam int BYTE_W          = 8;
  localparam int GRAV_W          = 12;
  localparam int SCALE_W         = 10;
  localparam int OUT_W           = 15;
  localparam int Q_SHIFT         = 8;

  // Register reset values
  localparam logic [GRAV_W-1:0]  GRAV_RESET  = 12'd2046;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd314;

  // Saturation limits of the Q8 outputs
  localparam int AXIS_MIN = -16384;
  localparam int AXIS_MAX = 16383;
  localparam int MAG_MAX  = 32767;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MS2_SCALE      = 2'd1;

  // Per-stage load enables of one axis lane
  typedef struct packed {
    logic en_a;  // load assembled count
    logic en_b;  // load scale product and square
    logic en_c;  // load saturated axis value
  } lane_ctl_t;

endpackage

### rtl/core/avm_lane.sv
// One axis lane: byte assembly, offset, Q8 scaling with saturation, squaring.
// Depends on avm_pkg.
`timescale 1ns / 1ps

module avm_lane #(
  parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF,
  parameter int CW          = SAMPLE_BITS + 1
) (
  input  logic                          clk,
  input  avm_pkg::lane_ctl_t            ctl,
  input  logic [avm_pkg::BYTE_W-1:0]    high,
  input  logic [avm_pkg::BYTE_W-1:0]    low,
  input  logic [avm_pkg::GRAV_W-1:0]    offset,
  input  logic [avm_pkg::SCALE_W-1:0]   scale,
  output logic [2*CW-2:0]               square,
  output logic signed [avm_pkg::OUT_W-1:0] accel
);

  localparam int QW = 2 * CW - 1;
  localparam int PW = CW + avm_pkg::SCALE_W + 1;

  logic [2*avm_pkg::BYTE_W-1:0] word;
  logic [SAMPLE_BITS-1:0]       raw;
  logic signed [CW-1:0]         cnt_next;
  logic signed [CW-1:0]         cnt;
  logic signed [PW-1:0]         cnt_ext;
  logic signed [PW-1:0]         scl_ext;
  logic signed [PW-1:0]         prod_next;
  logic signed [PW-1:0]         prod;
  logic signed [2*CW-1:0]       sq_full;
  logic [QW-1:0]                sq;
  logic signed [PW-1:0]         shifted;
  logic signed [avm_pkg::OUT_W-1:0] accel_next;

  // Assemble the count from the top bits of the byte pair and remove the offset
  always_comb begin
    word     = {high, low};
    raw      = word[2*avm_pkg::BYTE_W-1 -: SAMPLE_BITS];
    cnt_next = $signed({{(CW-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw})
             - $signed({{(CW-avm_pkg::GRAV_W){1'b0}}, offset});
  end

  always_ff @(posedge clk) begin
    if (ctl.en_a) begin
      cnt <= cnt_next;
    end
  end

  // Scale product and square, each in its own multiplier
  always_comb begin
    cnt_ext   = {{(PW-CW){cnt[CW-1]}}, cnt};
    scl_ext   = $signed({{(PW-avm_pkg::SCALE_W){1'b0}}, scale});
    prod_next = cnt_ext * scl_ext;
    sq_full   = $signed({cnt[CW-1], cnt}) * $signed({cnt[CW-1], cnt});
  end

  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      prod <= prod_next;
      sq   <= sq_full[QW-1:0];
    end
  end

  // Floor shift to Q8 and clamp to the signed output range
  always_comb begin
    shifted = prod >>> avm_pkg::Q_SHIFT;
    priority if (shifted < avm_pkg::AXIS_MIN) begin
      accel_next = avm_pkg::OUT_W'(avm_pkg::AXIS_MIN);
    end else if (shifted > avm_pkg::AXIS_MAX) begin
      accel_next = avm_pkg::OUT_W'(avm_pkg::AXIS_MAX);
    end else begin
      accel_next = shifted[avm_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      accel <= accel_next;
    end
  end

  assign square = sq;

endmodule

### rtl/core/avm_isqrt.sv
// Pipelined floor square root, one result bit per stage, with a passed-along tag.
// No dependencies on avm_pkg; standalone logic.
`timescale 1ns / 1ps

module avm_isqrt #(
  parameter int RW    = 16,
  parameter int TAG_W = 45
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  logic [2*RW-1:0]  rad_q  [RW];
  logic [RW:0]      rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [TAG_W-1:0] tag_q  [RW];
  logic [RW-1:0]    vld;
  logic [RW:0]      en;

  // Stage i loads when empty or when the stage after it moves on
  assign en[RW] = out_ready;
  genvar i;
  generate
    for (i = 0; i < RW; i++) begin : g_stage
      logic [2*RW-1:0]  rad_p;
      logic [RW:0]      rem_p;
      logic [RW-1:0]    root_p;
      logic [TAG_W-1:0] tag_p;
      logic             vld_p;
      logic [RW+2:0]    rem_sh;
      logic [RW+2:0]    trial;
      logic             ge;
      logic [RW+2:0]    rem_n;

      assign en[i] = !vld[i] || en[i+1];

      if (i == 0) begin : g_first
        assign rad_p  = in_rad;
        assign rem_p  = '0;
        assign root_p = '0;
        assign tag_p  = in_tag;
        assign vld_p  = in_valid;
      end else begin : g_next
        assign rad_p  = rad_q[i-1];
        assign rem_p  = rem_q[i-1];
        assign root_p = root_q[i-1];
        assign tag_p  = tag_q[i-1];
        assign vld_p  = vld[i-1];
      end

      // Bring down two radicand bits and try the next root bit
      always_comb begin
        rem_sh = {rem_p, rad_p[2*RW-1 -: 2]};
        trial  = {1'b0, root_p, 2'b01};
        ge     = (rem_sh >= trial);
        rem_n  = ge ? (rem_sh - trial) : rem_sh;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (en[i]) begin
          vld[i] <= vld_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en[i]) begin
          rad_q[i]  <= {rad_p[2*RW-3:0], 2'b00};
          rem_q[i]  <= rem_n[RW:0];
          root_q[i] <= {root_p[RW-2:0], ge};
          tag_q[i]  <= tag_p;
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = vld[RW-1];
  assign out_root  = root_q[RW-1];
  assign out_tag   = tag_q[RW-1];

endmodule

### rtl/core/accel_vector_magnitude.sv
// Top level of the accelerometer magnitude block: config registers, three axis
// lanes, sum of squares, square root pipeline and magnitude scaling.
// Depends on avm_pkg, avm_lane, avm_isqrt and accel_vector_magnitude_assert.svh.
`timescale 1ns / 1ps

// Converts one raw six-byte accelerometer sample per transfer into X, Y and Z
// acceleration and the vector magnitude, all in m/s^2 Q8. Three axis lanes
// work side by side (assemble, subtract gravity on Z, scale, square); their
// squares are summed and fed to a square root pipeline that settles one root
// bit per stage. A new sample is taken every cycle unless the output stalls;
// a transfer passes the three lane stages, the square root pipeline, the
// root scaling register and the output register. Any free stage absorbs a
// sample while a finished result waits on the output. Configuration writes
// take effect at once and should be made while no sample is in flight.
module accel_vector_magnitude #(
  parameter int SAMPLE_BITS = avm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Sample input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [7:0] x_high, [15:8] x_low, [23:16] y_high, [31:24] y_low,
  // [39:32] z_high, [47:40] z_low
  input  logic [47:0]                       s_tdata,
  // Result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [14:0] x_accel, [29:15] y_accel, [44:30] z_accel, [59:45] magnitude,
  // [63:60] zero
  output logic [63:0]                       m_tdata,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [avm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [avm_pkg::GRAV_W-1:0]        cfg_data
);

  localparam int CW    = ((SAMPLE_BITS > 13) ? SAMPLE_BITS : 13) + 1;
  localparam int QW    = 2 * CW - 1;
  localparam int SW    = QW + 2;
  localparam int RW    = (SW + 1) / 2;
  localparam int OW    = avm_pkg::OUT_W;
  localparam int TAG_W = 3 * OW;
  localparam int MW    = RW + avm_pkg::SCALE_W;

  logic [avm_pkg::GRAV_W-1:0]  gravity_offset;
  logic [avm_pkg::SCALE_W-1:0] ms2_scale;

  logic v_a, v_b, v_c, v_m;
  logic en_a, en_b, en_c, en_m, en_o;
  avm_pkg::lane_ctl_t lane_ctl;

  logic [QW-1:0]        sq_x, sq_y, sq_z;
  logic signed [OW-1:0] ax_x, ax_y, ax_z;
  logic [SW-1:0]        sum;
  logic [TAG_W-1:0]     tag_c;

  logic                 sq_in_ready;
  logic                 sq_out_valid;
  logic [RW-1:0]        root;
  logic [TAG_W-1:0]     root_tag;

  logic [MW-1:0]        mprod;
  logic [TAG_W-1:0]     tag_m;
  logic [MW-1:0]        mshift;
  logic [OW-1:0]        mag_next;
  logic [OW-1:0]        mag;
  logic [TAG_W-1:0]     tag_o;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_offset <= avm_pkg::GRAV_RESET;
      ms2_scale      <= avm_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avm_pkg::REG_GRAVITY_OFFSET: gravity_offset <= cfg_data;
        avm_pkg::REG_MS2_SCALE:      ms2_scale      <= cfg_data[avm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves on
  always_comb begin
    en_o = !m_tvalid || m_tready;
    en_m = !v_m || en_o;
    en_c = !v_c || sq_in_ready;
    en_b = !v_b || en_c;
    en_a = !v_a || en_b;
    lane_ctl.en_a = en_a;
    lane_ctl.en_b = en_b;
    lane_ctl.en_c = en_c;
  end

  assign s_tready = en_a;

  // Valid flags of the lane and output stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a      <= 1'b0;
      v_b      <= 1'b0;
      v_c      <= 1'b0;
      v_m      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_a) v_a <= s_tvalid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_m) v_m <= sq_out_valid;
      if (en_o) m_tvalid <= v_m;
    end
  end

  // Axis lanes; only Z removes the gravity offset
  avm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CW(CW)) u_lane_x (
    .clk    (clk),
    .ctl    (lane_ctl),
    .high   (s_tdata[7:0]),
    .low    (s_tdata[15:8]),
    .offset ({avm_pkg::GRAV_W{1'b0}}),
    .scale  (ms2_scale),
    .square (sq_x),
    .accel  (ax_x)
  );

  avm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CW(CW)) u_lane_y (
    .clk    (clk),
    .ctl    (lane_ctl),
    .high   (s_tdata[23:16]),
    .low    (s_tdata[31:24]),
    .offset ({avm_pkg::GRAV_W{1'b0}}),
    .scale  (ms2_scale),
    .square (sq_y),
    .accel  (ax_y)
  );

  avm_lane #(.SAMPLE_BITS(SAMPLE_BITS), .CW(CW)) u_lane_z (
    .clk    (clk),
    .ctl    (lane_ctl),
    .high   (s_tdata[39:32]),
    .low    (s_tdata[47:40]),
    .offset (gravity_offset),
    .scale  (ms2_scale),
    .square (sq_z),
    .accel  (ax_z)
  );

  // Merge: sum the three squares alongside the lanes' last stage
  always_ff @(posedge clk) begin
    if (en_c) begin
      sum <= {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    end
  end

  assign tag_c = {ax_z, ax_y, ax_x};

  avm_isqrt #(.RW(RW), .TAG_W(TAG_W)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_c),
    .in_ready  (sq_in_ready),
    .in_rad    ((2*RW)'(sum)),
    .in_tag    (tag_c),
    .out_valid (sq_out_valid),
    .out_ready (en_m),
    .out_root  (root),
    .out_tag   (root_tag)
  );

  // Scale the root to Q8
  always_ff @(posedge clk) begin
    if (en_m) begin
      mprod <= {{avm_pkg::SCALE_W{1'b0}}, root} * {{RW{1'b0}}, ms2_scale};
      tag_m <= root_tag;
    end
  end

  // Clamp the magnitude and hold the result for the output transfer
  always_comb begin
    mshift = mprod >> avm_pkg::Q_SHIFT;
    if (mshift > avm_pkg::MAG_MAX) begin
      mag_next = OW'(avm_pkg::MAG_MAX);
    end else begin
      mag_next = mshift[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      mag   <= mag_next;
      tag_o <= tag_m;
    end
  end

  assign m_tdata = {4'b0000, mag, tag_o};

  `include "accel_vector_magnitude_assert.svh"

  // An accepted sample occupies the first lane stage
  `AVM_ASSERT_NEXT(a_accept_fills, clk, rst, s_tvalid && s_tready, v_a)
  // An empty output register implies the whole pipeline can take a sample
  `AVM_ASSERT_NOW(a_empty_out_ready, clk, rst, !m_tvalid, s_tready)
  // A taken result with nothing behind it leaves the output empty
  `AVM_ASSERT_NEXT(a_drain_empty, clk, rst, m_tvalid && m_tready && !v_m, !m_tvalid)

endmodule
